// File: rtl/core/lru_cache_miss_classifier_core_defines.svh
// Assertion macros used by the checker file of the classifier core.
`ifndef LRU_CACHE_MISS_CLASSIFIER_CORE_DEFINES_SVH
`define LRU_CACHE_MISS_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LCMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcmc check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LCMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcmc check failed");

`endif

// File: rtl/core/lcmc_pkg.sv
// ----------------------------------------------------------------------------
// lcmc_pkg
// Shared constants, codes and types of the LRU cache miss classifier.
// ----------------------------------------------------------------------------
package lcmc_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int ADDR_BITS_DEF = 10;
  localparam int CFG_W         = 5;
  localparam int CNT_W         = 32;
  localparam int KIND_W        = 2;
  localparam int QDEPTH        = 4;

  localparam logic [CFG_W-1:0]  CAP_RST = 5'd16;
  localparam logic [CNT_W-1:0]  CNT_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_HIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAP  = 2'd2;

  // Control part of a word on its way from the front end to the back end.
  typedef struct packed {
    logic valid;
    logic seen;
  } lcmc_tok_t;

endpackage

// File: rtl/core/lcmc_front.sv
// ----------------------------------------------------------------------------
// lcmc_front
// Accepts access words, looks each address up in the seen map and marks it; clears the map after reset.
// ----------------------------------------------------------------------------
module lcmc_front #(
  parameter int ADDR_BITS = lcmc_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic                 q_room,
  output lcmc_pkg::lcmc_tok_t  tok,
  output logic [ADDR_BITS-1:0] tok_addr
);
  import lcmc_pkg::*;

  localparam int SPACE = 1 << ADDR_BITS;

  logic                 seen_mem [SPACE];
  logic                 seen_rd_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic                 valid_r;
  logic                 clr_r;
  logic [ADDR_BITS-1:0] clr_addr_r;
  logic                 accept;

  assign busy   = clr_r || !q_room;
  assign accept = start && !busy;

  // The read returns the bit as it stood before this access marks it.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      seen_mem[clr_addr_r] <= 1'b0;
    end else if (accept) begin
      seen_mem[in_address] <= 1'b1;
    end
    seen_rd_r <= seen_mem[in_address];
    addr_r    <= in_address;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      valid_r <= accept;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  assign tok.valid = valid_r;
  assign tok.seen  = seen_rd_r;
  assign tok_addr  = addr_r;

endmodule

// File: rtl/core/lcmc_queue.sv
// ----------------------------------------------------------------------------
// lcmc_queue
// Short FIFO of looked-up words between the front end and the back end.
// ----------------------------------------------------------------------------
module lcmc_queue #(
  parameter int ADDR_BITS = lcmc_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcmc_pkg::lcmc_tok_t  push_tok,
  input  logic [ADDR_BITS-1:0] push_addr,
  input  logic                 pop,
  output lcmc_pkg::lcmc_tok_t  head_tok,
  output logic [ADDR_BITS-1:0] head_addr,
  output logic                 room
);
  import lcmc_pkg::*;

  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  logic [ADDR_BITS-1:0] addr_q [QDEPTH];
  logic                 seen_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [QLVL_W-1:0]    level_r;
  logic                 push;
  logic                 do_pop;

  assign push   = push_tok.valid;
  assign do_pop = pop && (level_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      addr_q[wr_ptr_r] <= push_addr;
      seen_q[wr_ptr_r] <= push_tok.seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        level_r <= level_r + 1'b1;
      end else if (do_pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  assign head_tok.valid = (level_r != '0);
  assign head_tok.seen  = seen_q[rd_ptr_r];
  assign head_addr      = addr_q[rd_ptr_r];
  // One slot is kept spare for the word still in the front-end register.
  assign room           = (level_r < QLVL_W'(QDEPTH - 1));

endmodule

// File: rtl/core/lcmc_back.sv
// ----------------------------------------------------------------------------
// lcmc_back
// Tag match, LRU reordering, replacement and saturating statistics.
// ----------------------------------------------------------------------------
module lcmc_back #(
  parameter int ENTRIES   = lcmc_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = lcmc_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lcmc_pkg::CFG_W-1:0]    cfg_wdata,
  input  lcmc_pkg::lcmc_tok_t           in_tok,
  input  logic [ADDR_BITS-1:0]          in_addr,
  output logic                          pop,
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic [lcmc_pkg::KIND_W-1:0]   out_miss_kind,
  output logic [lcmc_pkg::CNT_W-1:0]    out_access_count,
  output logic [lcmc_pkg::CNT_W-1:0]    out_compulsory_count,
  output logic [lcmc_pkg::CNT_W-1:0]    out_capacity_count
);
  import lcmc_pkg::*;

  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  logic [CFG_W-1:0]     cap_r;
  logic [ADDR_BITS-1:0] tags_r   [ENTRIES];
  logic [ADDR_BITS-1:0] tags_nxt [ENTRIES];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]     acc_r, comp_r, capm_r;
  logic [CNT_W-1:0]     acc_nxt, comp_nxt, capm_nxt;
  logic                 strobe_r, hit_r;
  logic [KIND_W-1:0]    kind_r, kind_nxt;

  logic [CMP_W-1:0]     cap_ext, eff_cap, fill_ext;
  logic [ENTRIES-1:0]   match, shift_sel;
  logic                 found, evict, append;

  assign cap_ext  = CMP_W'(cap_r);
  assign fill_ext = CMP_W'(fill_r);

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      match[k] = (FILL_W'(k) < fill_r) && (tags_r[k] == in_addr);
    end
  end

  assign found  = |match;
  assign evict  = !found && (fill_ext >= eff_cap);
  assign append = !found && !evict;

  // An entry at or above the hit position moves down by one; on an eviction
  // every entry does.
  always_comb begin
    logic [ENTRIES-1:0] low_m;
    for (int k = 0; k < ENTRIES; k++) begin
      low_m        = match << (ENTRIES - 1 - k);
      shift_sel[k] = found ? (|low_m) : 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      tags_nxt[k] = tags_r[k];
      if (append) begin
        if (FILL_W'(k) == fill_r) begin
          tags_nxt[k] = in_addr;
        end
      end else if (FILL_W'(k + 1) == fill_r) begin
        tags_nxt[k] = in_addr;
      end else if (k < ENTRIES - 1) begin
        if (shift_sel[k] && (FILL_W'(k + 1) < fill_r)) begin
          tags_nxt[k] = tags_r[(k < ENTRIES - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_comb begin
    fill_nxt = append ? fill_r + 1'b1 : fill_r;
    acc_nxt  = (acc_r == CNT_MAX) ? acc_r : acc_r + 1'b1;
    comp_nxt = comp_r;
    capm_nxt = capm_r;
    if (found) begin
      kind_nxt = KIND_HIT;
    end else if (in_tok.seen) begin
      kind_nxt = KIND_CAP;
      capm_nxt = (capm_r == CNT_MAX) ? capm_r : capm_r + 1'b1;
    end else begin
      kind_nxt = KIND_COMP;
      comp_nxt = (comp_r == CNT_MAX) ? comp_r : comp_r + 1'b1;
    end
  end

  assign pop = in_tok.valid;

  always_ff @(posedge clk) begin
    if (in_tok.valid) begin
      for (int k = 0; k < ENTRIES; k++) begin
        tags_r[k] <= tags_nxt[k];
      end
      hit_r  <= found;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RST;
      fill_r   <= '0;
      acc_r    <= '0;
      comp_r   <= '0;
      capm_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      strobe_r <= in_tok.valid;
      if (in_tok.valid) begin
        fill_r <= fill_nxt;
        acc_r  <= acc_nxt;
        comp_r <= comp_nxt;
        capm_r <= capm_nxt;
      end
    end
  end

  assign out_strobe           = strobe_r;
  assign out_hit              = hit_r;
  assign out_miss_kind        = kind_r;
  assign out_access_count     = acc_r;
  assign out_compulsory_count = comp_r;
  assign out_capacity_count   = capm_r;

endmodule

// File: rtl/core/lru_cache_miss_classifier_core.sv
// Path: a word accepted by the front end passes the seen-map read register, the queue and
// the back-end result registers before its result is strobed.
// Throughput: one word per cycle while busy is low; tag match and LRU update are combinational.
// Reset: synchronous, active low; then busy stays high while all 2^ADDR_BITS seen-map bits
// (1024 by default) are cleared. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// lru_cache_miss_classifier_core
// Fully associative LRU cache with compulsory and capacity miss classification.
// ----------------------------------------------------------------------------
module lru_cache_miss_classifier_core #(
  parameter int ENTRIES   = lcmc_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = lcmc_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lcmc_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [ADDR_BITS-1:0]          in_address,
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic [lcmc_pkg::KIND_W-1:0]   out_miss_kind,
  output logic [lcmc_pkg::CNT_W-1:0]    out_access_count,
  output logic [lcmc_pkg::CNT_W-1:0]    out_compulsory_count,
  output logic [lcmc_pkg::CNT_W-1:0]    out_capacity_count
);
  import lcmc_pkg::*;

  lcmc_tok_t            fr_tok, hd_tok;
  logic [ADDR_BITS-1:0] fr_addr, hd_addr;
  logic                 q_room, q_pop;

  lcmc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_address (in_address),
    .q_room     (q_room),
    .tok        (fr_tok),
    .tok_addr   (fr_addr)
  );

  lcmc_queue #(.ADDR_BITS(ADDR_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_tok  (fr_tok),
    .push_addr (fr_addr),
    .pop       (q_pop),
    .head_tok  (hd_tok),
    .head_addr (hd_addr),
    .room      (q_room)
  );

  lcmc_back #(.ENTRIES(ENTRIES), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_tok               (hd_tok),
    .in_addr              (hd_addr),
    .pop                  (q_pop),
    .out_strobe           (out_strobe),
    .out_hit              (out_hit),
    .out_miss_kind        (out_miss_kind),
    .out_access_count     (out_access_count),
    .out_compulsory_count (out_compulsory_count),
    .out_capacity_count   (out_capacity_count)
  );

endmodule

// File: rtl/core/lcmc_checker.sv
// ----------------------------------------------------------------------------
// lcmc_checker
// Port-level checks on the classifier's result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_cache_miss_classifier_core_defines.svh"

module lcmc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic                        out_hit,
  input logic [lcmc_pkg::KIND_W-1:0] out_miss_kind,
  input logic [lcmc_pkg::CNT_W-1:0]  out_access_count,
  input logic [lcmc_pkg::CNT_W-1:0]  out_compulsory_count,
  input logic [lcmc_pkg::CNT_W-1:0]  out_capacity_count
);
  import lcmc_pkg::*;

  logic kind_ok;
  logic cnt_ok;

  assign kind_ok = (out_miss_kind == KIND_HIT) || (out_miss_kind == KIND_COMP) ||
                   (out_miss_kind == KIND_CAP);
  // Every miss is also an access, so neither miss count can run ahead.
  assign cnt_ok  = (out_compulsory_count <= out_access_count) &&
                   (out_capacity_count <= out_access_count);

  // The hit flag and the miss kind of one word must tell the same story.
  `LCMC_ASSERT_IMP(a_hit_kind, out_strobe, out_hit == (out_miss_kind == KIND_HIT))

  `LCMC_ASSERT_IMP(a_kind_legal, out_strobe, kind_ok)

  `LCMC_ASSERT_IMP(a_cnt_order, out_strobe, cnt_ok)

  // The queue never holds a word back; each result passes front, queue and back registers.
  `LCMC_ASSERT_IMP(a_no_early, out_strobe, $past(start && !busy, 3))

endmodule

bind lru_cache_miss_classifier_core lcmc_checker u_lcmc_checker (.*);

// File: bench/tb_lru_cache_miss_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_cache_miss_classifier_core
// Drives address words into the LRU miss classifier under several capacity
// settings, predicts hit, miss kind and the three counters in the bench, and
// checks every strobed result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_lru_cache_miss_classifier_core;
  import lcmc_pkg::*;

  localparam int ADDR_W  = ADDR_BITS_DEF;
  localparam int NSLOTS  = ENTRIES_DEF;
  localparam int NADDR   = 1 << ADDR_W;

  typedef enum logic [1:0] {PLAN_ACCESS, PLAN_CAPACITY, PLAN_DRAIN} plan_op_t;

  typedef struct {
    plan_op_t          op;
    logic [ADDR_W-1:0] addr;
    logic [CFG_W-1:0]  value;
    bit                steady;
  } plan_t;

  typedef struct {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  accesses;
    logic [CNT_W-1:0]  compulsory;
    logic [CNT_W-1:0]  capacity;
  } lookup_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ADDR_W-1:0]    in_address = '0;
  logic                 out_strobe;
  logic                 out_hit;
  logic [KIND_W-1:0]    out_miss_kind;
  logic [CNT_W-1:0]     out_access_count;
  logic [CNT_W-1:0]     out_compulsory_count;
  logic [CNT_W-1:0]     out_capacity_count;

  plan_t   access_plan[$];
  lookup_t lookup_q[$];
  int      words_sent = 0;
  int      lookups_seen = 0;
  int      mismatches = 0;
  int      capacity_writes = 0;
  int      hits_predicted = 0;
  int      compulsory_predicted = 0;
  int      capacity_predicted = 0;

  // Bench copy of the cache state.
  logic [ADDR_W-1:0] lru_tags [NSLOTS];
  int                lru_fill;
  bit                seen_map [NADDR];
  logic [CNT_W-1:0]  access_total;
  logic [CNT_W-1:0]  compulsory_total;
  logic [CNT_W-1:0]  capacity_total;
  logic [CFG_W-1:0]  cap_setting;

  lru_cache_miss_classifier_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_address           (in_address),
    .out_strobe           (out_strobe),
    .out_hit              (out_hit),
    .out_miss_kind        (out_miss_kind),
    .out_access_count     (out_access_count),
    .out_compulsory_count (out_compulsory_count),
    .out_capacity_count   (out_capacity_count)
  );

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic reset_lru_model();
    lru_fill = 0;
    for (int k = 0; k < NADDR; k++) seen_map[k] = 1'b0;
    for (int k = 0; k < NSLOTS; k++) lru_tags[k] = '0;
    access_total = '0;
    compulsory_total = '0;
    capacity_total = '0;
    cap_setting = CAP_RST;
  endtask

  // Removes one entry from the recency order; younger entries move down by one.
  task automatic drop_entry(input int pos);
    for (int k = pos + 1; k < lru_fill; k++) lru_tags[k-1] = lru_tags[k];
    if (lru_fill > 0) lru_fill--;
  endtask

  task automatic classify_access(input logic [ADDR_W-1:0] addr);
    int      limit;
    int      pos;
    bit      found;
    lookup_t r;
    limit = int'(cap_setting);
    if (limit == 0) limit = 1;
    else if (limit > NSLOTS) limit = NSLOTS;
    found = 1'b0;
    pos = 0;
    access_total = bump(access_total);
    for (int k = 0; k < lru_fill; k++) begin
      if (!found && lru_tags[k] == addr) begin
        found = 1'b1;
        pos = k;
      end
    end
    r.kind = KIND_HIT;
    if (found) begin
      drop_entry(pos);
      hits_predicted++;
    end else begin
      if (seen_map[addr]) begin
        r.kind = KIND_CAP;
        capacity_total = bump(capacity_total);
        capacity_predicted++;
      end else begin
        r.kind = KIND_COMP;
        compulsory_total = bump(compulsory_total);
        compulsory_predicted++;
      end
      // With the fill level at or above the capacity, a miss swaps one entry out.
      if (lru_fill >= limit) drop_entry(0);
    end
    if (lru_fill < NSLOTS) begin
      lru_tags[lru_fill] = addr;
      lru_fill++;
    end
    seen_map[addr] = 1'b1;
    r.hit = found;
    r.accesses = access_total;
    r.compulsory = compulsory_total;
    r.capacity = capacity_total;
    lookup_q = {lookup_q, r};
  endtask

  task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] want);
    mismatches++;
    $display("mismatch at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  // Sender: one word per accepted start, capacity writes only once the pipeline is empty.
  always @(posedge clk) begin : drive_proc
    logic go;
    logic we;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      cfg_wdata <= '0;
      in_address <= '0;
      reset_lru_model();
    end else begin
      if (cfg_we) cap_setting = cfg_wdata;
      if (start && !busy) begin
        classify_access(in_address);
        words_sent++;
      end
      go = start && busy;
      we = 1'b0;
      if (!go && access_plan.size() > 0) begin
        case (access_plan[0].op)
          PLAN_ACCESS: begin
            if (access_plan[0].steady || $urandom_range(99) >= 30) begin
              in_address <= access_plan[0].addr;
              go = 1'b1;
              void'(access_plan.pop_front());
            end
          end
          PLAN_CAPACITY: begin
            if (!busy && words_sent == lookups_seen) begin
              cfg_wdata <= access_plan[0].value;
              we = 1'b1;
              capacity_writes++;
              void'(access_plan.pop_front());
            end
          end
          default: begin
            if (words_sent == lookups_seen) void'(access_plan.pop_front());
          end
        endcase
      end
      start <= go;
      cfg_we <= we;
    end
  end

  always @(posedge clk) begin : check_proc
    lookup_t want;
    if (rst_n && out_strobe) begin
      lookups_seen <= lookups_seen + 1;
      if (lookup_q.size() == 0) begin
        flag_mismatch("result with no word waiting", out_access_count, '0);
      end else begin
        want = lookup_q.pop_front();
        if (out_hit !== want.hit)
          flag_mismatch("hit", CNT_W'(out_hit), CNT_W'(want.hit));
        if (out_miss_kind !== want.kind)
          flag_mismatch("miss_kind", CNT_W'(out_miss_kind), CNT_W'(want.kind));
        if (out_access_count !== want.accesses)
          flag_mismatch("access_count", out_access_count, want.accesses);
        if (out_compulsory_count !== want.compulsory)
          flag_mismatch("compulsory_count", out_compulsory_count, want.compulsory);
        if (out_capacity_count !== want.capacity)
          flag_mismatch("capacity_count", out_capacity_count, want.capacity);
      end
    end
  end

  task automatic plan_access(input logic [ADDR_W-1:0] addr, input bit steady);
    plan_t p;
    p.op = PLAN_ACCESS;
    p.addr = addr;
    p.value = '0;
    p.steady = steady;
    access_plan = {access_plan, p};
  endtask

  task automatic plan_capacity(input logic [CFG_W-1:0] value);
    plan_t p;
    p.op = PLAN_CAPACITY;
    p.addr = '0;
    p.value = value;
    p.steady = 1'b0;
    access_plan = {access_plan, p};
  endtask

  task automatic plan_drain();
    plan_t p;
    p.op = PLAN_DRAIN;
    p.addr = '0;
    p.value = '0;
    p.steady = 1'b0;
    access_plan = {access_plan, p};
  endtask

  // Accesses cluster round a drifting base so that hits and capacity misses are common;
  // a share of full-range addresses keeps compulsory misses coming.
  task automatic plan_phase(input logic [CFG_W-1:0] cap, input int count, input bit steady);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    int                span;
    plan_capacity(cap);
    base = ADDR_W'($urandom_range(NADDR - 1));
    span = $urandom_range(3, 40);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        base = ADDR_W'($urandom_range(NADDR - 1));
        span = $urandom_range(3, 40);
      end
      if ($urandom_range(99) < 15) addr = ADDR_W'($urandom_range(NADDR - 1));
      else addr = ADDR_W'(base + $urandom_range(span));
      plan_access(addr, steady);
      if (i % 70 == 69 && $urandom_range(1) == 1) plan_drain();
    end
  endtask

  initial begin : stim_proc
    logic [CFG_W-1:0] caps [13];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd4, 5'd8, 5'd15, 5'd3, 5'd16,
             5'd12, 5'd0};
    caps[12] = CFG_W'($urandom_range(31));

    // Reset capacity of sixteen: first touches are compulsory, repeats hit.
    plan_access('0, 1'b0);
    plan_access('1, 1'b0);
    plan_access('0, 1'b0);
    plan_access('1, 1'b0);
    plan_access(10'h155, 1'b0);
    plan_access(10'h2aa, 1'b0);
    // Capacity zero acts as one, and the four resident entries are only swapped out one by one.
    plan_capacity(5'd0);
    plan_access(10'h155, 1'b0);
    plan_access(10'h3c3, 1'b0);
    plan_access(10'h0f0, 1'b0);
    plan_access('0, 1'b0);
    plan_access(10'h3c3, 1'b0);
    plan_access(10'h00f, 1'b0);
    plan_access(10'h2aa, 1'b0);
    // A setting above the built entry count acts as the full cache.
    plan_capacity(5'd31);
    plan_access(10'h3c3, 1'b0);
    plan_access(10'h200, 1'b0);
    plan_access(10'h001, 1'b0);
    plan_access('1, 1'b0);
    // Capacity one with more entries resident than that: each miss evicts the oldest entry.
    plan_capacity(5'd1);
    for (int i = 0; i < 5; i++) plan_access(ADDR_W'(10'h040 + i), 1'b0);
    plan_access(10'h200, 1'b0);
    plan_drain();

    for (int ph = 0; ph < 13; ph++) plan_phase(caps[ph], 150, ph == 7);

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (access_plan.size() != 0 || start || words_sent != lookups_seen) @(negedge clk);
    repeat (8) @(negedge clk);
    if (lookup_q.size() != 0)
      flag_mismatch("words left without a result", CNT_W'(lookup_q.size()), '0);

    $display("Covered %0d words over %0d capacity writes, including zero and settings above %0d.",
             words_sent, capacity_writes, NSLOTS);
    $display("Predicted %0d hits, %0d compulsory and %0d capacity misses; %0d mismatches.",
             hits_predicted, compulsory_predicted, capacity_predicted, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #1ms;
    $display("Timed out with %0d words sent and %0d results seen.", words_sent, lookups_seen);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
